// ----- src/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, types and the sine table builder for the stereo flanger.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int DEF_BUFFER_SIZE     = 2048;
	localparam int DEF_SAMPLE_BITS     = 24;
	localparam int DEF_SINE_TABLE_BITS = 10;

	localparam int OUT_BITS       = 24;
	localparam int PHASE_W        = 32;
	localparam int DELAY_W        = 19;  // Q11.8 delay registers
	localparam int SINE_W         = 15;  // sine magnitude, Q1.15 without sign
	localparam int MAG_W          = DELAY_W + SINE_W - 16;
	localparam int DSUM_W         = DELAY_W + 2;  // predelay + depth +/- mag
	localparam int FRAC_BITS      = 8;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;

	localparam longint unsigned Q30_ONE    = 64'd1073741824;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PHASE_STEP     = 8'd0,
		CFG_DEPTH_DELAY    = 8'd1,
		CFG_PREDELAY_DELAY = 8'd2
	} sfd_cfg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [DELAY_W-1:0] depth_delay;
		logic [DELAY_W-1:0] predelay_delay;
	} sfd_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_DELAY,
		ST_ADDR,
		ST_INTERP
	} sfd_state_t;

	// per-lane strobes and read qualifiers from the sequencer
	typedef struct packed {
		logic                 cap;     // capture incoming sample
		logic                 rd_en;   // read both taps
		logic                 wr_en;   // store captured sample
		logic                 va;      // tap a was written since reset
		logic                 vb;      // tap b was written since reset
		logic [FRAC_BITS-1:0] frac;
	} sfd_lane_ctl_t;

	// Sine magnitude of quarter-wave entry m, Q1.15, Horner series in Q30.
	function automatic logic [SINE_W-1:0] sine_mag(int unsigned m, int unsigned bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned q;
		x  = (64'(m) * TWO_PI_Q30) >> bits;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		q  = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[SINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/sfd_if.sv -----
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the stereo flanger: input frames, output frames,
// and the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_in_if #(
	parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface sfd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sfd_pkg::OUT_BITS-1:0] out_left;
	logic signed [sfd_pkg::OUT_BITS-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

interface sfd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sfd_pkg::CFG_INDEX_BITS-1:0] index;
	logic [sfd_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/stereo_flanger_delay.sv -----
// ----------------------------------------------------------------------------
// stereo_flanger_delay
// Fully wet stereo flanger: LFO-modulated fractional delay per channel.
// ----------------------------------------------------------------------------
// Usage
//   frame_in  : one stereo request per frame (sample_left, sample_right).
//   frame_out : one interpolated stereo frame per input frame, in order.
//   cfg       : register writes, index 0 phase_step, 1 depth_delay,
//               2 predelay_delay (Q11.8 samples); other indexes are dropped.
//               Always ready; write only while no frame is in flight.
// Timing
//   A frame steps through sine lookup, depth multiply, delay sum/saturate,
//   two-tap store read, then interpolate into the output register. No new
//   frame is taken while one is in these steps; the next frame is accepted
//   on the edge that retires the previous one.
// Reset
//   arst_n clears the LFO phase, write index and registers. The stores are
//   not swept: a fill flag plus the write index mark which entries were
//   written, and unwritten entries read as zero, so no clearing pass.
// Backpressure
//   One frame may enter while the output is held; it then waits in the
//   interpolate step, and intake stalls until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_flanger_delay #(
	parameter int BUFFER_SIZE     = sfd_pkg::DEF_BUFFER_SIZE,
	parameter int SAMPLE_BITS     = sfd_pkg::DEF_SAMPLE_BITS,
	parameter int SINE_TABLE_BITS = sfd_pkg::DEF_SINE_TABLE_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfd_cfg_if.sink    cfg,
	sfd_in_if.sink     frame_in,
	sfd_out_if.source  frame_out
);
	import sfd_pkg::*;

	localparam int AW = $clog2(BUFFER_SIZE);

	sfd_cfg_t      cfg_q;
	sfd_lane_ctl_t lane_ctl;

	logic          in_ready;
	logic          finish;
	logic          out_free;
	logic          out_valid_q;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [AW-1:0] wr_addr;

	logic signed [OUT_BITS-1:0] res_left;
	logic signed [OUT_BITS-1:0] res_right;
	logic signed [OUT_BITS-1:0] out_left_q;
	logic signed [OUT_BITS-1:0] out_right_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PHASE_STEP:     cfg_q.phase_step     <= cfg.data[PHASE_W-1:0];
				CFG_DEPTH_DELAY:    cfg_q.depth_delay    <= cfg.data[DELAY_W-1:0];
				CFG_PREDELAY_DELAY: cfg_q.predelay_delay <= cfg.data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// output register frees when empty or being drained
	assign out_free = !out_valid_q || frame_out.ready;

	sfd_ctrl #(
		.BUFFER_SIZE     (BUFFER_SIZE),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.in_valid  (frame_in.valid),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.finish    (finish),
		.lane_ctl  (lane_ctl),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (wr_addr)
	);

	assign frame_in.ready = in_ready;

	// both lanes share addresses and strobes, each owns its store
	sfd_lane #(
		.BUFFER_SIZE (BUFFER_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_left (
		.clk       (clk),
		.ctl       (lane_ctl),
		.sample    (frame_in.sample_left),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (wr_addr),
		.result    (res_left)
	);

	sfd_lane #(
		.BUFFER_SIZE (BUFFER_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_right (
		.clk       (clk),
		.ctl       (lane_ctl),
		.sample    (frame_in.sample_right),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (wr_addr),
		.result    (res_right)
	);

	// merge: pack lane results into one output frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_left_q  <= res_left;
			out_right_q <= res_right;
		end
	end

	assign frame_out.valid     = out_valid_q;
	assign frame_out.out_left  = out_left_q;
	assign frame_out.out_right = out_right_q;

endmodule

`default_nettype wire

// ----- src/sfd_lane.sv -----
// ----------------------------------------------------------------------------
// sfd_lane
// One channel: circular delay store, two-tap read and linear interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_lane #(
	parameter int BUFFER_SIZE = sfd_pkg::DEF_BUFFER_SIZE,
	parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                 clk,
	input  wire sfd_pkg::sfd_lane_ctl_t               ctl,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	input  wire logic [$clog2(BUFFER_SIZE)-1:0]       rd_addr_a,
	input  wire logic [$clog2(BUFFER_SIZE)-1:0]       rd_addr_b,
	input  wire logic [$clog2(BUFFER_SIZE)-1:0]       wr_addr,
	output logic signed [sfd_pkg::OUT_BITS-1:0]       result
);
	import sfd_pkg::*;

	localparam int PW = SAMPLE_BITS + 10;           // interpolation sum width
	localparam int RW = SAMPLE_BITS + 2;            // after the 8-bit shift
	localparam int EW = SAMPLE_BITS + 2 + OUT_BITS;
	localparam logic signed [PW-1:0] ROUND = PW'(128);

	logic signed [SAMPLE_BITS-1:0] mem [BUFFER_SIZE];
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] rd_a_s4;
	logic signed [SAMPLE_BITS-1:0] rd_b_s4;

	logic signed [SAMPLE_BITS-1:0] tap_a;
	logic signed [SAMPLE_BITS-1:0] tap_b;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          sum;
	logic signed [RW-1:0]          res;
	logic signed [EW-1:0]          res_ext;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			sample_q <= sample;
		end
		if (ctl.wr_en) begin
			mem[wr_addr] <= sample_q;
		end
		if (ctl.rd_en) begin
			rd_a_s4 <= mem[rd_addr_a];
			rd_b_s4 <= mem[rd_addr_b];
		end
	end

	// unwritten entries read as zero
	assign tap_a  = ctl.va ? rd_a_s4 : '0;
	assign tap_b  = ctl.vb ? rd_b_s4 : '0;

	// (256-f)*a + f*b == 256*a + f*(b-a)
	assign diff    = (SAMPLE_BITS+1)'(tap_b) - (SAMPLE_BITS+1)'(tap_a);
	assign frac_s  = $signed({1'b0, ctl.frac});
	assign prod    = diff * frac_s;
	assign sum     = (PW'(tap_a) <<< FRAC_BITS) + prod + ROUND;
	assign res     = sum[PW-1:FRAC_BITS];
	assign res_ext = EW'(res);
	assign result  = res_ext[OUT_BITS-1:0];

endmodule

`default_nettype wire

// ----- src/sfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame sequencer: LFO and sine table, modulated delay, tap addresses,
// shared write index.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl #(
	parameter int BUFFER_SIZE     = sfd_pkg::DEF_BUFFER_SIZE,
	parameter int SINE_TABLE_BITS = sfd_pkg::DEF_SINE_TABLE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sfd_pkg::sfd_cfg_t              cfg_regs,
	input  wire logic                           in_valid,
	input  wire logic                           out_free,
	output logic                                in_ready,
	output logic                                finish,
	output sfd_pkg::sfd_lane_ctl_t              lane_ctl,
	output logic [$clog2(BUFFER_SIZE)-1:0]      rd_addr_a,
	output logic [$clog2(BUFFER_SIZE)-1:0]      rd_addr_b,
	output logic [$clog2(BUFFER_SIZE)-1:0]      wr_addr
);
	import sfd_pkg::*;

	localparam int AW      = $clog2(BUFFER_SIZE);
	localparam int QB      = SINE_TABLE_BITS - 2;
	localparam int QUARTER = 1 << QB;
	localparam int DW      = AW + FRAC_BITS;          // saturated delay width
	localparam int CW      = (DSUM_W > DW) ? DSUM_W : DW;
	localparam int PW      = AW + FRAC_BITS + 1;      // read position width
	localparam logic [CW-1:0] LIMIT = CW'((BUFFER_SIZE - 2) * 256);
	localparam logic [PW-1:0] SPAN  = PW'(BUFFER_SIZE * 256);
	localparam logic [AW-1:0] LAST  = AW'(BUFFER_SIZE - 1);

	sfd_state_t state_q, state_d;

	logic [SINE_W-1:0] rom_tab [QUARTER+1];

	logic [PHASE_W-1:0] lfo_q;
	logic [AW-1:0]      widx_q;
	logic               wrapped_q;
	logic [SINE_W-1:0]  rom_s1;
	logic               neg_s1;
	logic [MAG_W-1:0]   mag_s2;
	logic [DW-1:0]      d_s3;
	logic               va_s4;
	logic               vb_s4;
	logic [FRAC_BITS-1:0] frac_s4;

	logic                 accept;
	logic                 rd_en;
	logic [1:0]           quad;
	logic [QB-1:0]        k;
	logic [QB:0]          m;
	logic [DELAY_W+SINE_W-1:0] mag_full;
	logic [DSUM_W-1:0]    base;
	logic [DSUM_W-1:0]    d_raw;
	logic [CW-1:0]        d_ext;
	logic [PW-1:0]        pos_raw;
	logic [PW-1:0]        pos;
	logic [AW-1:0]        ia;
	logic [AW-1:0]        ib;

	// quarter-wave sine magnitudes, folded to constants at elaboration
	for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
		assign rom_tab[g] = sine_mag(g, SINE_TABLE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: begin
				state_d = ST_DELAY;
			end
			ST_DELAY: begin
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				rd_en   = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				if (out_free) begin
					finish   = 1'b1;
					in_ready = 1'b1;
					state_d  = in_valid ? ST_MAG : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// sine lookup from the current phase
	assign quad = lfo_q[PHASE_W-1 -: 2];
	assign k    = lfo_q[PHASE_W-3 -: QB];
	assign m    = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, k}) : {1'b0, k};

	assign mag_full = (DELAY_W+SINE_W)'(cfg_regs.depth_delay) * (DELAY_W+SINE_W)'(rom_s1);

	assign base  = DSUM_W'(cfg_regs.predelay_delay) + DSUM_W'(cfg_regs.depth_delay);
	assign d_raw = neg_s1 ? (base - DSUM_W'(mag_s2)) : (base + DSUM_W'(mag_s2));
	assign d_ext = CW'(d_raw);

	assign pos_raw = {1'b0, widx_q, {FRAC_BITS{1'b0}}} + SPAN - PW'(d_s3);
	assign pos     = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;
	assign ia      = pos[FRAC_BITS +: AW];
	assign ib      = (ia == LAST) ? '0 : (ia + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_q     <= '0;
			widx_q    <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (accept) begin
				lfo_q <= lfo_q + cfg_regs.phase_step;
			end
			if (finish) begin
				widx_q    <= (widx_q == LAST) ? '0 : (widx_q + 1'b1);
				wrapped_q <= wrapped_q || (widx_q == LAST);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rom_s1 <= rom_tab[m];
			neg_s1 <= quad[1];
		end
		if (state_q == ST_MAG) begin
			mag_s2 <= mag_full[16 +: MAG_W];
		end
		if (state_q == ST_DELAY) begin
			d_s3 <= (d_ext > LIMIT) ? LIMIT[DW-1:0] : d_ext[DW-1:0];
		end
		if (rd_en) begin
			va_s4   <= wrapped_q || (ia < widx_q);
			vb_s4   <= wrapped_q || (ib < widx_q);
			frac_s4 <= pos[FRAC_BITS-1:0];
		end
	end

	assign lane_ctl.cap   = accept;
	assign lane_ctl.rd_en = rd_en;
	assign lane_ctl.wr_en = finish;
	assign lane_ctl.va    = va_s4;
	assign lane_ctl.vb    = vb_s4;
	assign lane_ctl.frac  = frac_s4;

	assign rd_addr_a = ia;
	assign rd_addr_b = ib;
	assign wr_addr   = widx_q;

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("store fill flag cleared");

	a_taps_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (ia < AW'(BUFFER_SIZE - 1) || ia == LAST) && (ib < LAST || ib == LAST))
		else $error("tap address beyond store");

	a_delay_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> CW'(d_s3) <= LIMIT)
		else $error("delay above saturation limit");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INTERP && !out_free) |=> (state_q == ST_INTERP && $stable(widx_q)))
		else $error("frame retired while output full");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stereo_flanger_delay. A bit-true predictor keeps its
// own delay history, LFO phase and register copies, and works out the wet
// frame for every accepted input frame. Output frames are checked in order.
// Directed frames cover sample extremes, sub-sample delay, saturated delay and
// dropped register writes. Random phases then vary registers, samples and
// handshake timing on both sides.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	localparam int HIST_LEN    = DEF_BUFFER_SIZE;
	localparam int SMP_W       = DEF_SAMPLE_BITS;
	localparam int SINE_BITS   = DEF_SINE_TABLE_BITS;
	localparam int SINE_LEN    = 1 << SINE_BITS;
	localparam int QUARTER_LEN = SINE_LEN / 4;

	// delay saturates two samples short of the full history
	localparam longint MAX_DELAY_Q8 = longint'(HIST_LEN - 2) << FRAC_BITS;
	localparam longint SPAN_Q8      = longint'(HIST_LEN) << FRAC_BITS;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

	// register indexes the block must drop
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_A = 8'd3;
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_B = 8'd4;
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_C = 8'd5;
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_D = 8'd6;
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_E = 8'd128;
	localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_F = 8'd255;

	localparam int RANDOM_FRAMES = 1300;
	localparam int QUIET_LIMIT   = 4000;  // idle cycles before giving up
	localparam int SETTLE_CYCLES = 8;     // margin so the block is idle after draining
	localparam int LONG_HOLD     = 300;   // receiver hold-off, fills the pipe

	typedef struct {
		logic signed [OUT_BITS-1:0] out_left;
		logic signed [OUT_BITS-1:0] out_right;
	} wet_frame_t;

	// ------------------------------------------------------------------------
	// Predictor and in-order checker of wet frames
	// ------------------------------------------------------------------------
	class flanger_check;
		logic signed [SMP_W-1:0] hist_left [HIST_LEN];
		logic signed [SMP_W-1:0] hist_right[HIST_LEN];
		int unsigned             wr_ptr;
		logic [PHASE_W-1:0]      lfo_acc;
		logic [PHASE_W-1:0]      lfo_step;
		logic [DELAY_W-1:0]      depth_q8;
		logic [DELAY_W-1:0]      predelay_q8;
		int                      lfo_sine[SINE_LEN];
		wet_frame_t              wet_due[$];
		int                      bad_count;
		int                      seen_count;

		function new();
			int unsigned             quad;
			int unsigned             pos_in_quarter;
			int unsigned             mirrored;
			longint unsigned         ang;
			longint unsigned         ang2;
			longint unsigned         poly;
			longint unsigned         mag15;
			for (int i = 0; i < HIST_LEN; i++) begin
				hist_left[i]  = '0;
				hist_right[i] = '0;
			end
			wr_ptr      = 0;
			lfo_acc     = '0;
			lfo_step    = '0;
			depth_q8    = '0;
			predelay_q8 = '0;
			bad_count   = 0;
			seen_count  = 0;
			// full-wave table folded from the quarter wave, Horner series in Q30
			for (int i = 0; i < SINE_LEN; i++) begin
				quad           = i / QUARTER_LEN;
				pos_in_quarter = i % QUARTER_LEN;
				mirrored       = quad[0] ? QUARTER_LEN - pos_in_quarter : pos_in_quarter;
				ang   = (longint'(mirrored) * TWO_PI_Q30) >> SINE_BITS;
				ang2  = (ang * ang) >> 30;
				poly  = ONE_Q30 - ang2 / 110;
				poly  = ONE_Q30 - ((ang2 * poly) >> 30) / 72;
				poly  = ONE_Q30 - ((ang2 * poly) >> 30) / 42;
				poly  = ONE_Q30 - ((ang2 * poly) >> 30) / 20;
				poly  = ONE_Q30 - ((ang2 * poly) >> 30) / 6;
				mag15 = (((ang * poly) >> 30) + 64'd16384) >> 15;
				if (mag15 > 64'd32767) begin
					mag15 = 64'd32767;
				end
				lfo_sine[i] = quad[1] ? -int'(mag15) : int'(mag15);
			end
		endfunction

		function void apply_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				CFG_PHASE_STEP: begin
					lfo_step = val[PHASE_W-1:0];
				end
				CFG_DEPTH_DELAY: begin
					depth_q8 = val[DELAY_W-1:0];
				end
				CFG_PREDELAY_DELAY: begin
					predelay_q8 = val[DELAY_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// two-tap blend, round half up, floor shift
		function logic signed [OUT_BITS-1:0] blend(logic signed [SMP_W-1:0] tap_a,
				logic signed [SMP_W-1:0] tap_b, int unsigned frac);
			longint acc;
			acc = longint'(256 - int'(frac)) * longint'(tap_a)
				+ longint'(frac) * longint'(tap_b) + 128;
			return OUT_BITS'(acc >>> FRAC_BITS);
		endfunction

		function void note_frame(logic signed [SMP_W-1:0] in_left,
				logic signed [SMP_W-1:0] in_right);
			int         sn;
			longint     mod_q8;
			longint     dly_q8;
			longint     rd_q8;
			int         tap_a;
			int         tap_b;
			int         frac;
			wet_frame_t wet;
			sn     = lfo_sine[lfo_acc >> (PHASE_W - SINE_BITS)];
			mod_q8 = (longint'(depth_q8) * longint'(sn < 0 ? -sn : sn)) >>> 16;
			dly_q8 = longint'(predelay_q8) + longint'(depth_q8);
			dly_q8 = (sn >= 0) ? dly_q8 + mod_q8 : dly_q8 - mod_q8;
			if (dly_q8 > MAX_DELAY_Q8) begin
				dly_q8 = MAX_DELAY_Q8;
			end
			rd_q8 = ((longint'(wr_ptr) << FRAC_BITS) + SPAN_Q8 - dly_q8) % SPAN_Q8;
			tap_a = int'(rd_q8 >> FRAC_BITS);
			frac  = int'(rd_q8 % 256);
			tap_b = (tap_a + 1) % HIST_LEN;
			// read before write: a sub-sample delay sees the oldest entry
			wet.out_left  = blend(hist_left[tap_a], hist_left[tap_b], frac);
			wet.out_right = blend(hist_right[tap_a], hist_right[tap_b], frac);
			hist_left[wr_ptr]  = in_left;
			hist_right[wr_ptr] = in_right;
			wr_ptr  = (wr_ptr + 1) % HIST_LEN;
			lfo_acc = lfo_acc + lfo_step;
			wet_due.push_back(wet);
		endfunction

		function void check_frame(logic signed [OUT_BITS-1:0] got_left,
				logic signed [OUT_BITS-1:0] got_right);
			wet_frame_t want;
			seen_count++;
			if (wet_due.size() == 0) begin
				report_bad("unexpected frame", '0, got_left);
				return;
			end
			want = wet_due.pop_front();
			if (got_left !== want.out_left) begin
				report_bad("out_left", want.out_left, got_left);
			end
			if (got_right !== want.out_right) begin
				report_bad("out_right", want.out_right, got_right);
			end
		endfunction

		function void report_bad(string what, logic signed [OUT_BITS-1:0] want,
				logic signed [OUT_BITS-1:0] got);
			bad_count++;
			if (bad_count <= 10) begin
				$display("[%0t] frame %0d: %s expected %0d (0x%06h) got %0d (0x%06h)",
					$realtime, seen_count, what, want, want, got, got);
			end
		endfunction

		function int pending();
			return wet_due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always #5ns clk = ~clk;

	sfd_cfg_if                         cfg_ch();
	sfd_in_if #(.SAMPLE_BITS(SMP_W))   frame_in_ch();
	sfd_out_if                         frame_out_ch();

	stereo_flanger_delay #(
		.BUFFER_SIZE     (HIST_LEN),
		.SAMPLE_BITS     (SMP_W),
		.SINE_TABLE_BITS (SINE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_ch),
		.frame_in  (frame_in_ch),
		.frame_out (frame_out_ch)
	);

	flanger_check board = new();

	bit tx_throttle;     // sender inserts gaps between requests
	bit rx_throttle;     // receiver drops ready at random
	int hold_request;    // receiver hold-off, set by the sequence
	int frames_sent;
	int quiet_cycles;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	// Full-range samples with the edges thrown in often.
	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2:       return '0;
			3:       return '1;
			default: return SMP_W'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off on request.
	// Counts its own cycles so the sender keeps pushing meanwhile.
	// ------------------------------------------------------------------------
	initial begin
		int rx_idle;
		rx_idle = 0;
		frame_out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				frame_out_ch.ready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			if (rx_idle > 0) begin
				frame_out_ch.ready = 1'b0;
				rx_idle--;
			end else begin
				frame_out_ch.ready = 1'b1;
				if (rx_throttle && $urandom_range(0, 3) == 0) begin
					rx_idle = pick_gap();
				end
			end
		end
	end

	// Result check at the rising edge, pre-update values.
	always @(posedge clk) begin
		if (arst_n && frame_out_ch.valid && frame_out_ch.ready) begin
			board.check_frame(frame_out_ch.out_left, frame_out_ch.out_right);
		end
	end

	// Watchdog: any accepted request on any channel resets the count.
	always @(posedge clk) begin
		if ((frame_in_ch.valid && frame_in_ch.ready)
				|| (frame_out_ch.valid && frame_out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers. Inputs change on the falling edge only.
	// ------------------------------------------------------------------------

	// One input request. Valid stays high into the next call when no gap
	// follows; otherwise it drops on the next falling edge.
	task automatic send_frame(logic signed [SMP_W-1:0] smp_left,
			logic signed [SMP_W-1:0] smp_right, int gap);
		if (gap > 0) begin
			@(negedge clk);
			frame_in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		frame_in_ch.valid        = 1'b1;
		frame_in_ch.sample_left  = smp_left;
		frame_in_ch.sample_right = smp_right;
		do @(posedge clk); while (!frame_in_ch.ready);
		board.note_frame(smp_left, smp_right);
		frames_sent++;
	endtask

	function automatic int sender_gap();
		int r;
		if (!tx_throttle) begin
			return 0;
		end
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 0;
		end
		return (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	// Stop offering and wait for every outstanding wet frame, then a margin
	// so the block is idle before any register write.
	task automatic drain();
		@(negedge clk);
		frame_in_ch.valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do @(posedge clk); while (!cfg_ch.ready);
		board.apply_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Random register values: flanger-like ranges most of the time,
	// extremes and junk upper bits now and then.
	task automatic random_settings();
		logic [CFG_DATA_BITS-1:0] val;
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
				0:       val = '0;
				1:       val = '1;
				2:       val = $urandom_range(1, 1 << 16);
				3:       val = $urandom_range(1 << 20, 1 << 24);
				default: val = $urandom();
			endcase
			cfg_write(CFG_PHASE_STEP, val);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 7))
				0:       val = '0;
				1:       val = CFG_DATA_BITS'(DELAY_MAX);
				default: val = $urandom_range(0, 24 * 256);
			endcase
			val[CFG_DATA_BITS-1:DELAY_W] = (CFG_DATA_BITS-DELAY_W)'($urandom());
			cfg_write(CFG_DEPTH_DELAY, val);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 9))
				0:       val = '0;
				1:       val = CFG_DATA_BITS'(DELAY_MAX);
				2:       val = $urandom_range(0, 255);          // under one sample
				3:       val = $urandom_range(200 * 256, 1200 * 256);
				default: val = $urandom_range(256, 48 * 256);
			endcase
			val[CFG_DATA_BITS-1:DELAY_W] = (CFG_DATA_BITS-DELAY_W)'($urandom());
			cfg_write(CFG_PREDELAY_DELAY, val);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase_len;
		int phase_no;

		arst_n                   = 1'b0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.index             = '0;
		cfg_ch.data              = '0;
		frame_in_ch.valid        = 1'b0;
		frame_in_ch.sample_left  = '0;
		frame_in_ch.sample_right = '0;
		tx_throttle              = 1'b0;
		rx_throttle              = 1'b0;
		hold_request             = 0;
		frames_sent              = 0;
		quiet_cycles             = 0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Registers at reset: zero delay, so every read lands on the entry
		// about to be overwritten, i.e. the oldest one (still zero here).
		send_frame(SMP_MAX, SMP_MIN, 0);
		send_frame(SMP_MIN, SMP_MAX, 0);
		send_frame('0, '1, 0);
		send_frame('1, '0, 0);
		send_frame(24'h555555, 24'haaaaaa, 0);
		send_frame(24'haaaaaa, 24'h555555, 0);
		send_frame(SMP_MAX, SMP_MAX, 0);
		send_frame(SMP_MIN, SMP_MIN, 0);
		drain();

		// 1.5-sample predelay: halfway blend of neighbors, extreme pairs
		// exercise the round-half-up and the sign of the floor shift.
		cfg_write(CFG_PREDELAY_DELAY, 32'h0000_0180);
		send_frame(SMP_MAX, SMP_MIN, 0);
		send_frame(SMP_MIN, SMP_MAX, 0);
		send_frame(SMP_MAX, SMP_MAX, 0);
		send_frame('1, 24'sd1, 0);
		send_frame('0, '1, 0);
		send_frame(24'sd1, -24'sd2, 0);
		send_frame(24'h555555, 24'haaaaaa, 0);
		send_frame(SMP_MIN, SMP_MIN, 0);
		send_frame(SMP_MAX, 24'sd0, 0);
		send_frame(-24'sd3, 24'sd3, 0);
		drain();

		// Saturated delay, full depth with junk above bit 18, slowest
		// backward LFO; then writes to spare indexes that must be dropped.
		cfg_write(CFG_PHASE_STEP, '1);
		cfg_write(CFG_DEPTH_DELAY, '1);
		cfg_write(CFG_PREDELAY_DELAY, '1);
		cfg_write(IDX_SPARE_A, 32'h0000_0100);
		cfg_write(IDX_SPARE_B, 32'h0000_0000);
		cfg_write(IDX_SPARE_C, 32'h0000_0000);
		cfg_write(IDX_SPARE_D, 32'h0000_0000);
		cfg_write(IDX_SPARE_E, 32'h1234_5678);
		cfg_write(IDX_SPARE_F, 32'h0000_0000);
		send_frame(SMP_MAX, SMP_MIN, 0);
		send_frame(pick_sample(), pick_sample(), 0);
		send_frame(pick_sample(), pick_sample(), 0);
		send_frame(SMP_MIN, SMP_MAX, 0);
		send_frame('1, '0, 0);
		send_frame(pick_sample(), pick_sample(), 0);
		drain();

		// Random phases: new settings only while nothing is in flight.
		phase_no = 0;
		while (frames_sent < 24 + RANDOM_FRAMES) begin
			random_settings();
			tx_throttle = $urandom_range(0, 2) != 0;
			rx_throttle = $urandom_range(0, 2) != 0;
			phase_len   = $urandom_range(60, 160);
			if (phase_no == 0) begin
				// back-pressure test needs a sender that never lets up
				tx_throttle = 1'b0;
			end
			for (int i = 0; i < phase_len; i++) begin
				if (i == 20 && (phase_no == 0 || $urandom_range(0, 4) == 0)) begin
					// receiver stalls for a long stretch; intake must back up
					hold_request = LONG_HOLD;
				end
				if (i == phase_len / 2 && (phase_no == 1 || $urandom_range(0, 4) == 0)) begin
					// sender pause until the pipe is empty
					@(negedge clk);
					frame_in_ch.valid = 1'b0;
					while (board.pending() != 0) @(posedge clk);
				end
				send_frame(pick_sample(), pick_sample(), sender_gap());
			end
			drain();
			phase_no++;
		end

		// final wait for trailing frames and the latency margin
		drain();
		if (board.bad_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sfd_pkg.sv
src/sfd_if.sv
src/sfd_lane.sv
src/sfd_ctrl.sv
src/stereo_flanger_delay.sv
bench/tb.sv
